// ===== hdl/swlm_pkg.sv =====
// Shared types and codes for the segment window mapper.
`default_nettype none
package swlm_pkg;
    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_EVICT    = 3'd2,
        ST_NONE     = 3'd3,
        ST_RANGE    = 3'd4,
        ST_RELEASED = 3'd5,
        ST_REL_ERR  = 3'd6
    } t_status;

    localparam logic [1:0] CFG_SEG_LOG2 = 2'd0;
    localparam logic [1:0] CFG_BASE     = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_EXEC
    } t_bk_state;

    // Classified request handed from front to back.
    typedef struct packed {
        logic        unmap;
        logic        in_range;
        logic [46:0] seg;
        logic [29:0] seg_off;
        logic [47:0] back;
    } t_req;
endpackage
`default_nettype wire

// ===== hdl/swlm_front.sv =====
// Front end: splits a byte offset into segment and offset and queues the word.
`default_nettype none
module swlm_front
    import swlm_pkg::*;
#(
    parameter int NUM_SEGMENTS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic        i_req_type,
    input  wire logic [46:0] i_byte_offset,
    input  wire logic [4:0]  i_seg_log2,
    input  wire logic [46:0] i_base,
    input  wire logic        i_pop,
    output t_req             o_req,
    output logic             o_valid,
    output logic             o_full
);
    logic [4:0]  w_sh;
    logic [46:0] w_seg;
    logic [46:0] w_mask;
    t_req        w_req;
    t_req        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_comb begin
        w_sh = (i_seg_log2 < 5'd12) ? 5'd12 : ((i_seg_log2 > 5'd30) ? 5'd30 : i_seg_log2);
        w_seg  = i_byte_offset >> w_sh;
        w_mask = ~(47'h7fff_ffff_ffff << w_sh);
        w_req.unmap    = i_req_type;
        w_req.in_range = (w_seg < 47'(NUM_SEGMENTS));
        w_req.seg      = w_seg;
        w_req.seg_off  = 30'(i_byte_offset & w_mask);
        w_req.back     = {1'b0, i_base} + {1'b0, i_byte_offset & ~w_mask};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_take) begin
                r_q[r_wp] <= w_req;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_take) - 2'(i_pop);
        end
    end

    assign o_req   = r_q[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
endmodule
`default_nettype wire

// ===== hdl/swlm_back.sv =====
// Back end: segment table memory, window refcounts and the idle LRU list.
`default_nettype none
module swlm_back
    import swlm_pkg::*;
#(
    parameter int NUM_WINDOWS  = 16,
    parameter int NUM_SEGMENTS = 4096,
    parameter int REF_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_req        i_req,
    input  wire logic        i_valid,
    input  wire logic [4:0]  i_limit,
    output logic             o_pop,
    output logic             o_ready,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [3:0]       o_window_index,
    output logic [29:0]      o_offset_in_window,
    output logic             o_needs_mapping,
    output logic [47:0]      o_backing_offset,
    output logic             o_evicted_valid,
    output logic [11:0]      o_evicted_segment,
    output logic [31:0]      o_map_count
);
    localparam int WB = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int NB = $clog2(NUM_WINDOWS + 1);
    localparam int SB = $clog2(NUM_SEGMENTS);
    localparam logic [NB-1:0] NIL = NB'(NUM_WINDOWS);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Table entry: valid flag plus window; cleared by a sweep after reset.
    logic [WB:0]         r_tab [NUM_SEGMENTS];
    logic [WB:0]         r_rd;
    logic [SB-1:0]       r_clr;
    logic                r_clearing;
    logic [SB-1:0]       r_evseg_wr;
    logic                r_ev_pend;

    logic [SB-1:0]       r_wseg  [NUM_WINDOWS];
    logic [REF_BITS-1:0] r_refs  [NUM_WINDOWS];
    logic [NB-1:0]       r_prev  [NUM_WINDOWS];
    logic [NB-1:0]       r_next  [NUM_WINDOWS];
    logic [NB-1:0]       r_head, r_tail;
    logic [NB-1:0]       r_used;
    logic [31:0]         r_maps;

    t_bk_state r_state, n_state;
    t_req      r_cur;

    logic [SB-1:0] w_seg;
    logic [WB-1:0] w_w;
    logic [NB-1:0] w_lim;
    logic          w_hitv;

    assign w_seg  = r_cur.seg[SB-1:0];
    assign w_hitv = r_rd[WB];
    assign w_lim  = (i_limit == 5'd0) ? NB'(1) :
                    ((32'(i_limit) > NUM_WINDOWS) ? NIL : NB'(i_limit));

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: if (i_valid && !r_clearing && !r_ev_pend) begin
                o_pop = 1'b1;
                n_state = BK_LOOK;
            end
            BK_LOOK: n_state = BK_EXEC;
            BK_EXEC: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end
    assign o_ready = !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_req;
        r_rd <= r_tab[o_pop ? i_req.seg[SB-1:0] : w_seg];
    end

    // Widens a window index to a list pointer for linking a window into the list
    function automatic logic [NB-1:0] nb(input logic [WB-1:0] w);
        return NB'(w);
    endfunction

    always_ff @(posedge i_clk) begin
        logic [WB-1:0] w;
        logic [NB-1:0] p, nx;
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_ev_pend  <= 1'b0;
            r_head <= NIL;
            r_tail <= NIL;
            r_used <= '0;
            r_maps <= '0;
            o_done <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                r_refs[i] <= '0;
                r_prev[i] <= NIL;
                r_next[i] <= NIL;
            end
        end else begin
            o_done <= 1'b0;
            if (r_clearing) begin
                r_tab[r_clr] <= '0;
                r_clr <= r_clr + SB'(1);
                if (r_clr == SB'(NUM_SEGMENTS - 1)) r_clearing <= 1'b0;
            end else if (r_ev_pend) begin
                r_tab[r_evseg_wr] <= '0;
                r_ev_pend <= 1'b0;
            end
            if (r_state == BK_EXEC) begin
                w = r_rd[WB-1:0];
                o_done <= 1'b1;
                o_status <= ST_HIT;
                o_window_index <= '0;
                o_offset_in_window <= '0;
                o_needs_mapping <= 1'b0;
                o_backing_offset <= '0;
                o_evicted_valid <= 1'b0;
                o_evicted_segment <= '0;
                o_map_count <= r_maps;
                if (!r_cur.unmap) begin
                    if (!r_cur.in_range) begin
                        o_status <= ST_RANGE;
                    end else if (w_hitv) begin
                        if (r_refs[w] == '0) begin
                            p = r_prev[w]; nx = r_next[w];
                            if (p != NIL) r_next[p[WB-1:0]] <= nx; else r_head <= nx;
                            if (nx != NIL) r_prev[nx[WB-1:0]] <= p; else r_tail <= p;
                            r_prev[w] <= NIL; r_next[w] <= NIL;
                        end
                        if (r_refs[w] != REF_MAX) r_refs[w] <= r_refs[w] + REF_BITS'(1);
                        o_status <= ST_HIT;
                        o_window_index <= 4'(w);
                        o_offset_in_window <= r_cur.seg_off;
                    end else begin
                        if (r_used < w_lim && r_used < NIL) begin
                            w = r_used[WB-1:0];
                            r_used <= r_used + NB'(1);
                            o_status <= ST_NEW;
                        end else if (r_head != NIL) begin
                            w = r_head[WB-1:0];
                            nx = r_next[w];
                            r_head <= nx;
                            if (nx != NIL) r_prev[nx[WB-1:0]] <= NIL; else r_tail <= NIL;
                            r_prev[w] <= NIL; r_next[w] <= NIL;
                            r_evseg_wr <= r_wseg[w];
                            r_ev_pend <= 1'b1;
                            o_evicted_valid <= 1'b1;
                            o_evicted_segment <= 12'(r_wseg[w]);
                            o_status <= ST_EVICT;
                        end else begin
                            o_status <= ST_NONE;
                        end
                        if ((r_used < w_lim && r_used < NIL) || r_head != NIL) begin
                            r_wseg[w] <= w_seg;
                            r_refs[w] <= REF_BITS'(1);
                            r_tab[w_seg] <= {1'b1, w};
                            if (r_maps != 32'hffff_ffff) begin
                                r_maps <= r_maps + 32'd1;
                                o_map_count <= r_maps + 32'd1;
                            end
                            o_window_index <= 4'(w);
                            o_offset_in_window <= r_cur.seg_off;
                            o_needs_mapping <= 1'b1;
                            o_backing_offset <= r_cur.back;
                        end
                    end
                end else begin
                    if (!r_cur.in_range || !w_hitv || r_refs[w] == '0) begin
                        o_status <= ST_REL_ERR;
                    end else begin
                        r_refs[w] <= r_refs[w] - REF_BITS'(1);
                        if (r_refs[w] == REF_BITS'(1)) begin
                            r_next[w] <= NIL;
                            r_prev[w] <= r_tail;
                            if (r_tail != NIL) r_next[r_tail[WB-1:0]] <= nb(w);
                            else r_head <= nb(w);
                            r_tail <= nb(w);
                        end
                        o_status <= ST_RELEASED;
                        o_window_index <= 4'(w);
                        o_offset_in_window <= r_cur.seg_off;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/segment_window_lru_mapper_core.sv =====
// Top level of the segment window mapper: config registers, front and back.
`default_nettype none
// Each request produces one result word, strobed by o_done for one cycle. After the
// accepting edge the word passes the two-entry queue, the back end's look-up state
// and its execute state before o_done rises, and it waits longer while earlier
// words in the queue are served. The back end takes one word at a time and takes no
// new word until it has done the look-up read and update of the segment table
// memory; an eviction holds off the next word while the old table entry is cleared.
// busy is high while the queue holds two words, and after reset during a clearing
// pass over the table. The receiver cannot stall results.
module segment_window_lru_mapper_core
    import swlm_pkg::*;
#(
    parameter int NUM_WINDOWS  = 16,
    parameter int NUM_SEGMENTS = 4096,
    parameter int REF_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [46:0] i_byte_offset,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [46:0] i_cfg_data,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [3:0]       o_window_index,
    output logic [29:0]      o_offset_in_window,
    output logic             o_needs_mapping,
    output logic [47:0]      o_backing_offset,
    output logic             o_evicted_valid,
    output logic [11:0]      o_evicted_segment,
    output logic [31:0]      o_map_count
);
    logic [4:0]  r_seg_log2;
    logic [46:0] r_base;
    logic [4:0]  r_limit;
    t_req        w_req;
    logic        w_valid, w_full, w_pop, w_ready, w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_log2 <= 5'd16;
            r_base     <= '0;
            r_limit    <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEG_LOG2: r_seg_log2 <= i_cfg_data[4:0];
                CFG_BASE:     r_base     <= i_cfg_data;
                CFG_LIMIT:    r_limit    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign busy   = w_full || !w_ready;
    assign w_take = start && !busy;

    swlm_front #(.NUM_SEGMENTS(NUM_SEGMENTS)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_req_type, .i_byte_offset,
        .i_seg_log2(r_seg_log2), .i_base(r_base), .i_pop(w_pop),
        .o_req(w_req), .o_valid(w_valid), .o_full(w_full)
    );

    swlm_back #(.NUM_WINDOWS(NUM_WINDOWS), .NUM_SEGMENTS(NUM_SEGMENTS),
                .REF_BITS(REF_BITS)) u_back (
        .i_clk, .i_rst_n, .i_req(w_req), .i_valid(w_valid), .i_limit(r_limit),
        .o_pop(w_pop), .o_ready(w_ready), .o_done, .o_status, .o_window_index,
        .o_offset_in_window, .o_needs_mapping, .o_backing_offset,
        .o_evicted_valid, .o_evicted_segment, .o_map_count
    );

    a_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_needs_mapping == (o_status == ST_NEW || o_status == ST_EVICT)))
        else $error("needs_mapping disagrees with status");
    a_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_evicted_valid |-> o_status == ST_EVICT)
        else $error("eviction flag without evict status");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid)
        else $error("pop from empty queue");
endmodule
`default_nettype wire
